FILE: rtl/rumble_envelope_mixer_defines.svh
// Assertion macros shared by the rumble envelope mixer checkers.
// No dependencies.
`ifndef RUMBLE_ENVELOPE_MIXER_DEFINES_SVH
`define RUMBLE_ENVELOPE_MIXER_DEFINES_SVH

// Same-cycle implication under the active-low reset
`define REM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rumble mixer check failed");

// Next-cycle implication under the active-low reset
`define REM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rumble mixer check failed");

`endif

FILE: rtl/rem_pkg.sv
// Shared constants and types for the rumble envelope mixer.
// No dependencies.
package rem_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int BUZZ_TICKS = 16384;
    localparam int SLOT_W     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // divider widths: (elapsed << 16) / decay_time
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 24;
    localparam int DCNT_W     = $clog2(DIVIDEND_W);

    // command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ADD      = 3'd1;
    localparam logic [2:0] CMD_BUZZ     = 3'd2;
    localparam logic [2:0] CMD_CLEAR    = 3'd3;
    localparam logic [2:0] CMD_EXPLICIT = 3'd4;

    // one event table word
    typedef struct packed {
        logic [16:0]        level;
        logic [16:0]        mix;
        logic signed [24:0] hold;
        logic [23:0]        decay;
    } ev_entry_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

FILE: rtl/rumble_envelope_mixer.sv
// Two-motor haptic envelope engine top level.
// Depends on rem_pkg and rem_divider.
//
// Usage:
//   Requests enter on in_valid/in_ready with command, paused, elapsed,
//   level, mix, hold_time, decay_time and gain. Only a tick request makes a
//   result on out_valid/out_ready (drive_left, drive_right, post,
//   overflow_seen); add, buzz, clear and explicit-level requests make none.
//   A tick walks the event table slot by slot out of a single-port RAM:
//   a free slot is only scanned; a live slot in hold, with zero level or
//   with zero decay is scanned, multiplied and updated; a decaying slot
//   then also waits on the serial divider before its write-back.
//   One request is in work at a time; in_ready is high while idle, also
//   while a finished result waits in the output register.
//   If the receiver stalls, a tick finishes its walk and then waits with
//   the result held until the older result is taken.
//   Reset frees all slots (valid flops), clears the levels, the buzz and
//   the overflow flag; table contents need no clearing.
module rumble_envelope_mixer
    import rem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic        paused,
    input  logic [15:0] elapsed,
    input  logic [16:0] level,
    input  logic [16:0] mix,
    input  logic [23:0] hold_time,
    input  logic [23:0] decay_time,
    input  logic [15:0] gain,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] drive_left,
    output logic [16:0] drive_right,
    output logic        post,
    output logic        overflow_seen
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    ev_entry_t ev_mem [MAX_EVENTS];
    ev_entry_t rd_data_reg;

    logic [2:0]             state_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [MAX_EVENTS-1:0]  used_reg;
    logic [15:0]            dt_reg;
    logic                   paused_reg;
    logic [16:0]            explicit_reg;
    logic [16:0]            cur_l_reg;
    logic [16:0]            cur_r_reg;
    logic                   buzz_active_reg;
    logic signed [24:0]     buzz_time_reg;
    logic [16:0]            buzz_level_reg;
    logic                   dropped_reg;
    logic [33:0]            prod_l_reg;
    logic [33:0]            prod_r_reg;
    logic                   out_valid_reg;
    logic [16:0]            out_l_reg;
    logic [16:0]            out_r_reg;
    logic                   out_post_reg;
    logic                   out_ovf_reg;

    logic                   accept;
    logic                   last_slot;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic [32:0]            gain_prod;
    logic [16:0]            add_level;
    logic [16:0]            add_mix;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_wa;
    ev_entry_t              mem_wd;
    logic [16:0]            share_l;
    logic [16:0]            share_r;
    logic                   hold_pos;
    logic signed [24:0]     hold_dec;
    logic [16:0]            decayed;
    logic signed [24:0]     buzz_dec;
    logic                   fin_go;
    div_ctrl_t              div_ctl;
    logic [DIVIDEND_W-1:0]  div_quo;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign last_slot = (idx_reg == SLOT_W'(MAX_EVENTS - 1));
    assign fin_go    = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // first free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_EVENTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // add-event scaling and mix saturation
    assign gain_prod = level * gain;
    assign add_level = (gain_prod[32:12] > 21'(ONE_Q16)) ? ONE_Q16 : gain_prod[28:12];
    assign add_mix   = (mix > ONE_Q16) ? ONE_Q16 : mix;

    // per-slot update terms
    assign share_l  = prod_l_reg[32:16];
    assign share_r  = prod_r_reg[32:16];
    assign hold_pos = !rd_data_reg.hold[24] && (rd_data_reg.hold != '0);
    assign hold_dec = rd_data_reg.hold - $signed({9'd0, dt_reg});
    assign decayed  = (div_quo >= 32'(rd_data_reg.level)) ? 17'd0
                                                          : 17'(32'(rd_data_reg.level) - div_quo);
    assign buzz_dec = buzz_time_reg - $signed({9'd0, dt_reg});

    assign div_ctl.start = (state_reg == ST_UPD) && hold_pos == 1'b0
                           && rd_data_reg.level != '0 && rd_data_reg.decay != '0;

    rem_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend ({dt_reg, 16'd0}),
        .divisor  (rd_data_reg.decay),
        .done     (div_ctl.done),
        .quotient (div_quo)
    );

    // table write port: adds while idle, write-back during a walk
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = rd_data_reg;
        if (accept && command == CMD_ADD && !paused && free_found)
        begin
            mem_we       = 1'b1;
            mem_wa       = free_slot;
            mem_wd.level = add_level;
            mem_wd.mix   = add_mix;
            mem_wd.hold  = $signed({1'b0, hold_time});
            mem_wd.decay = decay_time;
        end
        else if (state_reg == ST_UPD && hold_pos)
        begin
            mem_we      = 1'b1;
            mem_wd.hold = hold_dec;
        end
        else if (state_reg == ST_UPD && rd_data_reg.level != '0
                 && rd_data_reg.decay == '0)
        begin
            mem_we       = 1'b1;
            mem_wd.level = '0;
        end
        else if (state_reg == ST_DIV && div_ctl.done)
        begin
            mem_we       = 1'b1;
            mem_wd.level = decayed;
        end
    end

    // event table RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ev_mem[mem_wa] <= mem_wd;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= ev_mem[idx_reg];
        end
    end

    // share products
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_l_reg <= rd_data_reg.level * (ONE_Q16 - rd_data_reg.mix);
            prod_r_reg <= rd_data_reg.level * rd_data_reg.mix;
        end
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            used_reg        <= '0;
            dt_reg          <= '0;
            paused_reg      <= 1'b0;
            explicit_reg    <= '0;
            cur_l_reg       <= '0;
            cur_r_reg       <= '0;
            buzz_active_reg <= 1'b0;
            buzz_time_reg   <= -25'sd65536;
            buzz_level_reg  <= '0;
            dropped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        dt_reg     <= elapsed;
                        paused_reg <= paused;
                        case (command)
                            CMD_ADD:
                            begin
                                if (!paused)
                                begin
                                    if (free_found)
                                    begin
                                        used_reg[free_slot] <= 1'b1;
                                    end
                                    else
                                    begin
                                        dropped_reg <= 1'b1;
                                    end
                                end
                            end
                            CMD_BUZZ:
                            begin
                                buzz_active_reg <= 1'b1;
                                buzz_time_reg   <= 25'(BUZZ_TICKS);
                                buzz_level_reg  <= (level > ONE_Q16) ? ONE_Q16 : level;
                            end
                            CMD_CLEAR:
                            begin
                                explicit_reg <= '0;
                                cur_l_reg    <= '0;
                                cur_r_reg    <= '0;
                                used_reg     <= '0;
                            end
                            CMD_EXPLICIT:
                            begin
                                explicit_reg <= (level > ONE_Q16) ? ONE_Q16 : level;
                            end
                            CMD_TICK:
                            begin
                                idx_reg <= '0;
                                if (paused)
                                begin
                                    state_reg <= ST_FIN;
                                end
                                else
                                begin
                                    cur_l_reg    <= explicit_reg;
                                    cur_r_reg    <= explicit_reg;
                                    explicit_reg <= '0;
                                    state_reg    <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (used_reg[idx_reg])
                    begin
                        state_reg <= ST_MUL;
                    end
                    else if (last_slot)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (share_l > cur_l_reg)
                    begin
                        cur_l_reg <= share_l;
                    end
                    if (share_r > cur_r_reg)
                    begin
                        cur_r_reg <= share_r;
                    end
                    if (div_ctl.start)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        // hold, zero-decay and zero-level free all finish here
                        if (!hold_pos && rd_data_reg.level == '0)
                        begin
                            used_reg[idx_reg] <= 1'b0;
                        end
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= last_slot ? ST_FIN : ST_SCAN;
                    end
                end
                ST_DIV:
                begin
                    if (div_ctl.done)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= last_slot ? ST_FIN : ST_SCAN;
                    end
                end
                ST_FIN:
                begin
                    if (fin_go)
                    begin
                        state_reg <= ST_IDLE;
                        if (buzz_active_reg)
                        begin
                            buzz_time_reg <= buzz_dec;
                            if (buzz_dec[24])
                            begin
                                buzz_active_reg <= 1'b0;
                            end
                            if (buzz_level_reg > cur_l_reg)
                            begin
                                cur_l_reg <= buzz_level_reg;
                            end
                            if (buzz_level_reg > cur_r_reg)
                            begin
                                cur_r_reg <= buzz_level_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_post_reg <= !paused_reg || buzz_active_reg;
            out_ovf_reg  <= dropped_reg;
            if (buzz_active_reg && buzz_level_reg > cur_l_reg)
            begin
                out_l_reg <= buzz_level_reg;
            end
            else
            begin
                out_l_reg <= cur_l_reg;
            end
            if (buzz_active_reg && buzz_level_reg > cur_r_reg)
            begin
                out_r_reg <= buzz_level_reg;
            end
            else
            begin
                out_r_reg <= cur_r_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_left    = out_l_reg;
    assign drive_right   = out_r_reg;
    assign post          = out_post_reg;
    assign overflow_seen = out_ovf_reg;

endmodule

FILE: rtl/rem_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rem_pkg.
module rem_divider
    import rem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DCNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    // trial subtract
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIVISOR_W'(shifted - {1'b0, dvs_reg})
                            : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/rem_checker.sv
// Port-level checks for the rumble envelope mixer, bound to the top level.
// Depends on rumble_envelope_mixer_defines.svh.
`include "rumble_envelope_mixer_defines.svh"

module rem_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] drive_left,
    input logic [16:0] drive_right,
    input logic        post,
    input logic        overflow_seen
);

    // a waiting request stays offered
    `REM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

    // a stalled result holds its levels and post
    `REM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(drive_left) && $stable(drive_right) && $stable(post))

    // levels never pass 1.0
    `REM_ASSERT_NOW(a_left_range, clk, rst_n, out_valid, drive_left <= 17'd65536)
    `REM_ASSERT_NOW(a_right_range, clk, rst_n, out_valid, drive_right <= 17'd65536)

    // overflow flag is sticky across results
    `REM_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, out_valid && overflow_seen, !out_valid || overflow_seen)

endmodule

bind rumble_envelope_mixer rem_checker u_rem_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_left    (drive_left),
    .drive_right   (drive_right),
    .post          (post),
    .overflow_seen (overflow_seen)
);
